// ===== sv/upd_pkg.sv =====
// Shared types, character constants and helper functions for the URL
// percent decoder. No dependencies; imported by every upd_* module.
package upd_pkg;

    // Characters with special meaning in the encoded stream
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    // Configuration register indexes
    localparam logic [2:0] REG_PLUS  = 3'd0;
    localparam logic [2:0] REG_AMP   = 3'd1;
    localparam logic [2:0] REG_SEMI  = 3'd2;
    localparam logic [2:0] REG_EQ    = 3'd3;
    localparam logic [2:0] REG_SLASH = 3'd4;

    // Output queue depth and results per item
    localparam int QDEPTH   = 4;
    localparam int MAX_RES  = 3;

    // Substitution bytes from the configuration registers
    typedef struct packed {
        logic [7:0] plus_sub;
        logic [7:0] amp_sub;
        logic [7:0] semicolon_sub;
        logic [7:0] equals_sub;
        logic [7:0] slash_sub;
    } upd_subs_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } upd_item_t;

    // Results of one input item handed to the output queue
    typedef struct packed {
        logic [1:0]            cnt;
        upd_item_t [MAX_RES-1:0] items;
    } upd_push_t;

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    // Replace the separator characters + & ; = by their configured bytes
    function automatic logic [7:0] subst(input logic [7:0] b, input upd_subs_t s);
        logic [7:0] r;
        r = b;
        if (b == CH_PLUS) begin
            r = s.plus_sub;
        end else if (b == CH_AMP) begin
            r = s.amp_sub;
        end else if (b == CH_SEMI) begin
            r = s.semicolon_sub;
        end else if (b == CH_EQ) begin
            r = s.equals_sub;
        end
        return r;
    endfunction

endpackage

// ===== sv/url_percent_decoder.sv =====
// URL percent decoder, top level: configuration registers, decoder stage and
// output queue. An accepted item's results pass from the input register through
// the output queue to m_*. Throughput: one item per cycle; the 4-entry output
// queue stalls s_tready only while an item's results (up to 3) do not fit.
// Reset (aresetn low, synchronous) empties both stages, clears pending state
// and loads the default substitutes. Depends on upd_pkg, upd_decode, upd_outq.
module url_percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // in_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,    // run_last
    output logic       m_tuser,    // string_end
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import upd_pkg::*;

    upd_subs_t subs_reg;
    upd_push_t push;
    logic [2:0] space;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subs_reg.plus_sub      <= CH_PLUS - 8'h0b;
            subs_reg.amp_sub       <= CH_AMP;
            subs_reg.semicolon_sub <= CH_SEMI;
            subs_reg.equals_sub    <= CH_EQ;
            subs_reg.slash_sub     <= CH_SLASH;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PLUS:  subs_reg.plus_sub      <= cfg_data;
                REG_AMP:   subs_reg.amp_sub       <= cfg_data;
                REG_SEMI:  subs_reg.semicolon_sub <= cfg_data;
                REG_EQ:    subs_reg.equals_sub    <= cfg_data;
                REG_SLASH: subs_reg.slash_sub     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    upd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .subs     (subs_reg),
        .space    (space),
        .push     (push)
    );

    upd_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sv/upd_decode.sv =====
// Input register, percent-sequence state and decode logic. Produces up to
// three result items per input item. Depends on upd_pkg.
module upd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] in_byte
    input  logic              s_tlast,    // in_end
    input  upd_pkg::upd_subs_t subs,
    input  logic [2:0]        space,
    output upd_pkg::upd_push_t push
);
    import upd_pkg::*;

    typedef enum logic [1:0] {
        PC_IDLE = 2'd0,
        PC_PCT  = 2'd1,
        PC_DIG  = 2'd2
    } pend_t;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    pend_t      pc_reg, pc_next;
    logic [7:0] held_reg, held_next;

    logic [4:0] hv_b, hv_h;
    logic       b_hex, b_pct;
    logic       f_emit;
    logic [7:0] f_byte;
    pend_t      f_pc;
    logic [7:0] dec_byte;
    logic [1:0] n_res;
    logic [7:0] rb [MAX_RES];
    logic       s1_move;

    // Fresh-byte handling shared by all pending states
    always_comb begin
        hv_b     = hex_val(s1_byte_reg);
        hv_h     = hex_val(held_reg);
        b_hex    = ~hv_b[4];
        b_pct    = (s1_byte_reg == CH_PCT);
        f_emit   = ~b_pct | s1_end_reg;
        f_byte   = b_pct ? CH_PCT : subst(s1_byte_reg, subs);
        f_pc     = (b_pct && !s1_end_reg) ? PC_PCT : PC_IDLE;
        dec_byte = {hv_h[3:0], hv_b[3:0]};
        if (dec_byte == CH_SLASH) begin
            dec_byte = subs.slash_sub;
        end
    end

    // Result list and next state for the item in the input register
    always_comb begin
        rb[0]     = f_byte;
        rb[1]     = f_byte;
        rb[2]     = f_byte;
        n_res     = {1'b0, f_emit};
        pc_next   = f_pc;
        held_next = held_reg;
        unique case (pc_reg)
            PC_PCT: begin
                if (b_hex) begin
                    if (s1_end_reg) begin
                        rb[0]   = CH_PCT;
                        rb[1]   = s1_byte_reg;
                        n_res   = 2'd2;
                        pc_next = PC_IDLE;
                    end else begin
                        n_res     = 2'd0;
                        pc_next   = PC_DIG;
                        held_next = s1_byte_reg;
                    end
                end else begin
                    rb[0] = CH_PCT;
                    rb[1] = f_byte;
                    n_res = 2'd1 + {1'b0, f_emit};
                end
            end
            PC_DIG: begin
                if (b_hex) begin
                    rb[0]   = subst(dec_byte, subs);
                    n_res   = 2'd1;
                    pc_next = PC_IDLE;
                end else begin
                    rb[0] = CH_PCT;
                    rb[1] = held_reg;
                    rb[2] = f_byte;
                    n_res = 2'd2 + {1'b0, f_emit};
                end
            end
            default: begin
            end
        endcase
        if (s1_end_reg) begin
            pc_next   = PC_IDLE;
            held_next = 8'h00;
        end
    end

    // Hand the item to the queue only when all its results fit
    assign s1_move  = s1_valid_reg && ({1'b0, n_res} <= space);
    assign s_tready = ~s1_valid_reg | s1_move;

    always_comb begin
        push.cnt = s1_move ? n_res : 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            push.items[k].out_byte   = rb[k];
            push.items[k].run_last   = (2'(k) == n_res - 2'd1);
            push.items[k].string_end = (2'(k) == n_res - 2'd1) & s1_end_reg;
        end
    end

    // Input register and decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            pc_reg       <= PC_IDLE;
            held_reg     <= 8'h00;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_move) begin
                pc_reg   <= pc_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_byte_reg <= s_tdata;
            s1_end_reg  <= s_tlast;
        end
    end

    // A string end leaves nothing pending
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move && s1_end_reg |=> pc_reg == PC_IDLE && held_reg == 8'h00)
        else $error("pending state survives end of string");

    // A string end always yields at least one result
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move && s1_end_reg |-> push.cnt != 2'd0)
        else $error("end of string produced no result");

endmodule

// ===== sv/upd_outq.sv =====
// Shifting output queue of result items; entry 0 is the output register.
// Each cycle up to 3 items in, one out on m_tready. Depends on upd_pkg.
module upd_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  upd_pkg::upd_push_t push,
    output logic [2:0]        space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,    // [7:0] out_byte
    output logic              m_tlast,    // run_last
    output logic              m_tuser     // string_end
);
    import upd_pkg::*;

    upd_item_t  q_reg [QDEPTH];
    upd_item_t  q_next [QDEPTH];
    logic [2:0] count_reg, count_next;
    logic [2:0] base;
    logic [2:0] k;
    logic       pop;

    assign pop      = m_tvalid & m_tready;
    assign space    = 3'(QDEPTH) - count_reg + {2'b00, pop};
    assign base     = count_reg - {2'b00, pop};
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = q_reg[0].out_byte;
    assign m_tlast  = q_reg[0].run_last;
    assign m_tuser  = q_reg[0].string_end;

    // Shift on pop, then append new items behind the survivors
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_next[i] = q_reg[i];
            if (pop && i < QDEPTH - 1) begin
                q_next[i] = q_reg[i + 1];
            end
            k = 3'(i) - base;
            if (3'(i) >= base && k < {1'b0, push.cnt}) begin
                q_next[i] = push.items[k[1:0]];
            end
        end
        count_next = base + {1'b0, push.cnt};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    // Fill level stays within the queue
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QDEPTH))
        else $error("output queue overfilled");

    // Pushes never exceed the room left after this cycle's pop
    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> {1'b0, push.cnt} <= space)
        else $error("push larger than free space");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the URL percent decoder (url_percent_decoder).
// Drives encoded strings on the s_ stream, predicts the decoded m_ stream and
// checks it item by item. Depends on upd_pkg and the decoder RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;     // a result passes the input register and then the output queue

    // Indexes past the last register; writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Decoder pending state
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // ASCII anchors for hex digit generation
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_NINE  = 8'h39;
    localparam logic [7:0] ASC_UP_A  = 8'h41;
    localparam logic [7:0] ASC_UP_F  = 8'h46;
    localparam logic [7:0] ASC_LO_A  = 8'h61;
    localparam logic [7:0] ASC_LO_F  = 8'h66;
    localparam logic [7:0] ASC_LO_E  = 8'h65;
    localparam logic [7:0] ASC_UP_D  = 8'h44;
    localparam logic [7:0] ASC_LO_B  = 8'h62;
    localparam logic [7:0] ASC_LO_Z  = 8'h7a;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_last;
        logic       string_end;
    } decoded_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_data  = 8'h00;

    // Predictor state: substitutes and pending percent sequence
    upd_subs_t  subs = {8'd32, 8'd38, 8'd59, 8'd61, 8'd47};
    logic [1:0] pend_state = PEND_NONE;
    logic [7:0] held_char  = 8'h00;

    decoded_t   expected_bytes[$];
    int         error_count   = 0;
    int         items_sent    = 0;
    int         cycle_count   = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left     = 0;

    url_percent_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Nibble value of a hex digit; bit 4 set for anything else
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= ASC_ZERO && b <= ASC_NINE) return {1'b0, 4'(b - ASC_ZERO)};
        if (b >= ASC_LO_A && b <= ASC_LO_F) return {1'b0, 4'(b - ASC_LO_A + 8'd10)};
        if (b >= ASC_UP_A && b <= ASC_UP_F) return {1'b0, 4'(b - ASC_UP_A + 8'd10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] map_separator(input logic [7:0] b);
        case (b)
            CH_PLUS: return subs.plus_sub;
            CH_AMP:  return subs.amp_sub;
            CH_SEMI: return subs.semicolon_sub;
            CH_EQ:   return subs.equals_sub;
            default: return b;
        endcase
    endfunction

    // Advance the decoder model by one accepted item and queue its results
    task automatic predict_decode(input logic [7:0] b, input logic last_in);
        logic [7:0] outs[$];
        logic [4:0] nv;
        logic [4:0] hv_held;
        logic [7:0] dec;
        logic       fresh;
        decoded_t   r;
        nv = nibble_of(b);
        fresh = 1'b0;
        case (pend_state)
            PEND_PCT: begin
                if (!nv[4] && last_in) begin
                    outs = {outs, CH_PCT};
                    outs = {outs, b};
                    pend_state = PEND_NONE;
                end else if (!nv[4]) begin
                    held_char = b;
                    pend_state = PEND_DIGIT;
                end else begin
                    outs = {outs, CH_PCT};
                    fresh = 1'b1;
                end
            end
            PEND_DIGIT: begin
                if (!nv[4]) begin
                    hv_held = nibble_of(held_char);
                    dec = {hv_held[3:0], nv[3:0]};
                    if (dec == CH_SLASH) dec = subs.slash_sub;
                    outs = {outs, map_separator(dec)};
                    pend_state = PEND_NONE;
                end else begin
                    outs = {outs, CH_PCT};
                    outs = {outs, held_char};
                    fresh = 1'b1;
                end
            end
            default: fresh = 1'b1;
        endcase
        // Current byte taken as the start of something new
        if (fresh) begin
            if (b == CH_PCT && !last_in) begin
                pend_state = PEND_PCT;
            end else begin
                outs = {outs, map_separator(b)};
                pend_state = PEND_NONE;
            end
        end
        if (last_in) begin
            pend_state = PEND_NONE;
            held_char = 8'h00;
        end
        foreach (outs[k]) begin
            r.data_byte  = outs[k];
            r.run_last   = (k == outs.size() - 1);
            r.string_end = (k == outs.size() - 1) && last_in;
            expected_bytes = {expected_bytes, r};
        end
    endtask

    // ---------------------------------------------------------------- checker

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch %s: got %02h expected %02h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, 8'h00);
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data_byte)
                    report_mismatch("out_byte", m_tdata, want.data_byte);
                if (m_tlast !== want.run_last)
                    report_mismatch("run_last", m_tlast, want.run_last);
                if (m_tuser !== want.string_end)
                    report_mismatch("string_end", m_tuser, want.string_end);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Offer one item; valid stays high afterwards unless an idle gap follows
    task automatic send_item(input logic [7:0] b, input logic last_in);
        int n_idle;
        n_idle = 0;
        while (n_idle < 20 && $urandom_range(99) < send_idle_pct) n_idle++;
        if (n_idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (n_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last_in;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_decode(b, last_in);
        items_sent++;
    endtask

    task automatic send_string(input logic [7:0] str[$]);
        foreach (str[k]) send_item(str[k], k == str.size() - 1);
    endtask

    // Stop offering, wait for every expected item and let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_PLUS:  subs.plus_sub      = val;
            REG_AMP:   subs.amp_sub       = val;
            REG_SEMI:  subs.semicolon_sub = val;
            REG_EQ:    subs.equals_sub    = val;
            REG_SLASH: subs.slash_sub     = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- generators

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return ASC_ZERO + {4'h0, n};
        return (upper ? ASC_UP_A : ASC_LO_A) + {4'h0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(5))
            0: return CH_PLUS;
            1: return CH_AMP;
            2: return CH_SEMI;
            3: return CH_EQ;
            4: return CH_PCT;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        logic [4:0] nv;
        do begin
            b  = 8'($urandom_range(255));
            nv = nibble_of(b);
        end while (!nv[4]);
        return b;
    endfunction

    function automatic logic [7:0] pick_sub();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hff;
            2: return special_char();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly well-formed strings: plain bytes, separators and escapes,
    // with some broken escapes and raw noise mixed in
    task automatic send_random_string();
        logic [7:0] str[$];
        logic [7:0] code;
        int         len;
        int         kind;
        len = $urandom_range(12, 1);
        while (str.size() < len) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                str = {str, 8'($urandom_range(255))};
            end else if (kind < 50) begin
                str = {str, special_char()};
            end else if (kind < 82) begin
                code = ($urandom_range(3) == 0) ? special_char() : 8'($urandom_range(255));
                str = {str, CH_PCT};
                str = {str, hex_char(code[7:4], 1'($urandom_range(1)))};
                str = {str, hex_char(code[3:0], 1'($urandom_range(1)))};
            end else if (kind < 88) begin
                str = {str, CH_PCT};
                str = {str, non_hex_char()};
            end else if (kind < 94) begin
                str = {str, CH_PCT};
                str = {str, hex_char(4'($urandom_range(15)), 1'($urandom_range(1)))};
                if ($urandom_range(1)) str = {str, non_hex_char()};
            end else begin
                str = {str, CH_PCT};
            end
        end
        send_string(str);
    endtask

    task automatic randomize_subs();
        write_reg(REG_PLUS,  pick_sub());
        write_reg(REG_AMP,   pick_sub());
        write_reg(REG_SEMI,  pick_sub());
        write_reg(REG_EQ,    pick_sub());
        write_reg(REG_SLASH, pick_sub());
        if ($urandom_range(1))
            write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), pick_sub());
    endtask

    // ---------------------------------------------------------------- tests

    // Separators, escapes, broken escapes and cut-off sequences at reset config
    task automatic test_escapes_default();
        send_string('{CH_PLUS, CH_AMP, CH_SEMI, CH_EQ, 8'h00, 8'hff,
                      CH_PCT, 8'h34, 8'h31,               // valid escape
                      CH_PCT, 8'h32, ASC_LO_F,            // escaped slash
                      CH_PCT, ASC_LO_Z,                   // non-hex after percent
                      CH_PCT, 8'h34, CH_PCT,              // non-hex after digit
                      CH_PCT,                             // percent after percent
                      ASC_LO_A});                         // cut off after digit
        send_string('{CH_PCT});                           // lone percent at end
        send_string('{CH_PCT, ASC_LO_E, CH_PCT});         // three items from one
        drain();
    endtask

    // Extreme substitutes, slash mapped onto a separator, spare indexes ignored
    task automatic test_register_writes();
        write_reg(REG_SLASH, CH_PLUS);
        write_reg(REG_PLUS,  8'h00);
        write_reg(REG_AMP,   8'hff);
        write_reg(REG_SEMI,  8'h00);
        write_reg(REG_EQ,    8'hff);
        write_reg(REG_SPARE_LO, 8'h55);
        write_reg(REG_SPARE_HI, 8'haa);
        send_string('{CH_PCT, 8'h32, ASC_UP_F, CH_PLUS, CH_AMP,
                      CH_PCT, 8'h33, ASC_LO_B, CH_PCT, 8'h33, ASC_UP_D});
        drain();
    endtask

    task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int target;
        randomize_subs();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + n_items;
        while (items_sent < target) send_random_string();
        drain();
    endtask

    // Receiver holds off long enough for the output queue to back up
    task automatic test_output_backpressure();
        int target;
        randomize_subs();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        target = items_sent + 40;
        while (items_sent < target) send_random_string();
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_escapes_default();
        test_register_writes();
        test_random_strings(0, 0, 100);
        test_random_strings(46, 0, 100);
        test_random_strings(0, 46, 100);
        test_random_strings(14, 14, 100);
        test_output_backpressure();

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
